### src/rolt_pkg.sv
// rolt_pkg: shared types and codes for the resource ownership lock table
// depends on nothing; used by rolt_find_free and the core top level
package rolt_pkg;

   localparam int MAX_UNITS      = 64;
   localparam int UNIT_BITS      = 6;
   localparam int CLASS_BITS     = 3;
   localparam int INST_PORT_BITS = 8;
   localparam int OP_BITS        = 2;
   localparam int STATUS_BITS    = 3;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_LOCK     = 2'd0;
   localparam logic [OP_BITS-1:0] OP_LOCK_ANY = 2'd1;
   localparam logic [OP_BITS-1:0] OP_UNLOCK   = 2'd2;
   localparam logic [OP_BITS-1:0] OP_RESERVED = 2'd3;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_GRANTED   = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_OTHER     = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NONE_FREE = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD       = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_UNLOCKED  = 3'd4;

   // pool selector
   localparam logic POOL_PINS   = 1'b0;
   localparam logic POOL_TIMERS = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // lowest free unit search result
   typedef struct packed {
      logic                 found;
      logic [UNIT_BITS-1:0] unit;
   } find_result_type;

endpackage

### src/resource_ownership_lock_table_core.sv
// a transaction accepted at one edge reads the holder memory and enters the execute
// state; the decision is registered into the response (rsp_strobe), which is held
// for exactly one cycle; no new transaction is accepted until the read-modify-write
// execute cycle is done; busy is high during the execute cycle
// reset: synchronous; all taken flags clear at once (timer 0 held by system, instance 0),
// no clearing pass; results cannot be stalled by the receiver
module resource_ownership_lock_table_core
   import rolt_pkg::*;
#(
   parameter int PIN_COUNT     = 64,
   parameter int TIMER_COUNT   = 9,
   parameter int INSTANCE_BITS = 8
)
(
   input  logic                      clock,
   input  logic                      reset,

   // request channel
   input  logic                      start,
   output logic                      busy,
   input  logic [OP_BITS-1:0]        req_operation,
   input  logic                      req_pool,
   input  logic [UNIT_BITS-1:0]      req_unit_index,
   input  logic [CLASS_BITS-1:0]     req_requester_class,
   input  logic [INST_PORT_BITS-1:0] req_requester_instance,

   // response channel
   output logic                      rsp_strobe,
   output logic [STATUS_BITS-1:0]    rsp_status,
   output logic                      rsp_granted,
   output logic [UNIT_BITS-1:0]      rsp_chosen_unit,
   output logic [CLASS_BITS-1:0]     rsp_holder_class,
   output logic [INST_PORT_BITS-1:0] rsp_holder_instance
);

   // only the low instance bits are kept, and never more than the port carries
   localparam int INST_KEEP = (INSTANCE_BITS < INST_PORT_BITS) ? INSTANCE_BITS
                                                               : INST_PORT_BITS;
   localparam int HOLD_BITS = CLASS_BITS + INST_KEEP;
   localparam int ADDR_BITS = UNIT_BITS + 1;
   localparam int MEM_DEPTH = 2 * MAX_UNITS;

   // units that exist in each pool
   localparam logic [MAX_UNITS-1:0] PIN_MASK   = {MAX_UNITS{1'b1}} >> (MAX_UNITS - PIN_COUNT);
   localparam logic [MAX_UNITS-1:0] TIMER_MASK = {MAX_UNITS{1'b1}} >> (MAX_UNITS - TIMER_COUNT);
   localparam logic [UNIT_BITS:0]   PIN_LIMIT   = (UNIT_BITS + 1)'(PIN_COUNT);
   localparam logic [UNIT_BITS:0]   TIMER_LIMIT = (UNIT_BITS + 1)'(TIMER_COUNT);

   // control state
   state_type              state_ff, state_in;
   logic [MAX_UNITS-1:0]   pin_taken_ff, pin_taken_in;
   logic [MAX_UNITS-1:0]   timer_taken_ff, timer_taken_in;
   logic                   t0_written_ff, t0_written_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   // captured transaction
   logic [OP_BITS-1:0]        op_ff;
   logic                      pool_ff;
   logic [UNIT_BITS-1:0]      unit_ff;
   logic [CLASS_BITS-1:0]     cls_ff;
   logic [INST_PORT_BITS-1:0] inst_ff;
   find_result_type           find_ff;
   logic                      rd_t0_ff;

   // response payload
   logic [STATUS_BITS-1:0]    status_ff, status_in;
   logic                      granted_ff, granted_in;
   logic [UNIT_BITS-1:0]      chosen_ff, chosen_in;
   logic [HOLD_BITS-1:0]      holder_ff, holder_in;

   // holder memory, addressed by {pool, unit}
   logic [HOLD_BITS-1:0]      holder_mem [MEM_DEPTH];
   logic [HOLD_BITS-1:0]      rd_data_ff;
   logic                      mem_we;
   logic [ADDR_BITS-1:0]      mem_waddr;

   logic                      accept;
   logic [MAX_UNITS-1:0]      free_vec;
   find_result_type           find_result;
   logic [HOLD_BITS-1:0]      req_holder;
   logic [HOLD_BITS-1:0]      rd_holder;
   logic                      unit_ok;
   logic                      taken_bit;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff == ST_EXEC);

   // free units of the requested pool, searched at accept time
   assign free_vec = (req_pool == POOL_TIMERS) ? (~timer_taken_ff & TIMER_MASK)
                                               : (~pin_taken_ff & PIN_MASK);

   rolt_find_free u_find_free (
      .free_vec (free_vec),
      .result   (find_result)
   );

   // memory: read at accept, write back during the execute cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         holder_mem[mem_waddr] <= req_holder;
      end
      if (accept) begin
         rd_data_ff <= holder_mem[{req_pool, req_unit_index}];
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         pool_ff  <= req_pool;
         unit_ff  <= req_unit_index;
         cls_ff   <= req_requester_class;
         inst_ff  <= req_requester_instance;
         find_ff  <= find_result;
         // timer 0 holder reads its reset value until first written
         rd_t0_ff <= (req_pool == POOL_TIMERS) && (req_unit_index == '0) && !t0_written_ff;
      end
   end

   assign req_holder = {cls_ff, inst_ff[INST_KEEP-1:0]};
   assign rd_holder  = rd_t0_ff ? '0 : rd_data_ff;
   assign unit_ok    = {1'b0, unit_ff} < ((pool_ff == POOL_TIMERS) ? TIMER_LIMIT : PIN_LIMIT);
   assign taken_bit  = (pool_ff == POOL_TIMERS) ? timer_taken_ff[unit_ff]
                                                : pin_taken_ff[unit_ff];

   // execute cycle: decide, update taken flags, write the holder back
   always_comb begin
      state_in       = state_ff;
      pin_taken_in   = pin_taken_ff;
      timer_taken_in = timer_taken_ff;
      t0_written_in  = t0_written_ff;
      rsp_strobe_in  = 1'b0;
      status_in      = status_ff;
      granted_in     = granted_ff;
      chosen_in      = chosen_ff;
      holder_in      = holder_ff;
      mem_we         = 1'b0;
      mem_waddr      = {pool_ff, unit_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            status_in     = STATUS_BAD;
            granted_in    = 1'b0;
            chosen_in     = unit_ff;
            holder_in     = '0;
            case (op_ff)
               OP_LOCK_ANY: begin
                  if (find_ff.found) begin
                     status_in  = STATUS_GRANTED;
                     granted_in = 1'b1;
                     chosen_in  = find_ff.unit;
                     holder_in  = req_holder;
                     mem_we     = 1'b1;
                     mem_waddr  = {pool_ff, find_ff.unit};
                     if (pool_ff == POOL_TIMERS) begin
                        timer_taken_in[find_ff.unit] = 1'b1;
                     end else begin
                        pin_taken_in[find_ff.unit] = 1'b1;
                     end
                  end else begin
                     status_in = STATUS_NONE_FREE;
                     chosen_in = '0;
                  end
               end
               OP_LOCK: begin
                  if (unit_ok) begin
                     if (!taken_bit) begin
                        // free unit: requester becomes the holder
                        status_in  = STATUS_GRANTED;
                        granted_in = 1'b1;
                        holder_in  = req_holder;
                        mem_we     = 1'b1;
                        if (pool_ff == POOL_TIMERS) begin
                           timer_taken_in[unit_ff] = 1'b1;
                        end else begin
                           pin_taken_in[unit_ff] = 1'b1;
                        end
                     end else if (rd_holder == req_holder) begin
                        // already ours
                        status_in  = STATUS_GRANTED;
                        granted_in = 1'b1;
                        holder_in  = req_holder;
                     end else begin
                        status_in = STATUS_OTHER;
                        holder_in = rd_holder;
                     end
                  end
               end
               OP_UNLOCK: begin
                  if (unit_ok) begin
                     status_in = STATUS_UNLOCKED;
                     if (pool_ff == POOL_TIMERS) begin
                        timer_taken_in[unit_ff] = 1'b0;
                     end else begin
                        pin_taken_in[unit_ff] = 1'b0;
                     end
                  end
               end
               default: begin
                  status_in = STATUS_BAD;
               end
            endcase
            if (mem_we && (mem_waddr == {POOL_TIMERS, UNIT_BITS'(0)})) begin
               t0_written_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pin_taken_ff   <= '0;
         timer_taken_ff <= MAX_UNITS'(1);
         t0_written_ff  <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pin_taken_ff   <= pin_taken_in;
         timer_taken_ff <= timer_taken_in;
         t0_written_ff  <= t0_written_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // response payload registers
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      granted_ff <= granted_in;
      chosen_ff  <= chosen_in;
      holder_ff  <= holder_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_granted         = granted_ff;
   assign rsp_chosen_unit     = chosen_ff;
   assign rsp_holder_class    = holder_ff[HOLD_BITS-1:INST_KEEP];
   assign rsp_holder_instance = INST_PORT_BITS'(holder_ff[INST_KEEP-1:0]);

`ifndef SYNTHESIS
   // every accepted transaction moves into the execute cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not enter execute");

   // a response only follows an execute cycle
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response strobe without execute cycle");

   // granted responses always carry the granted status
   a_granted_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_granted) |-> (rsp_status == STATUS_GRANTED))
      else $error("granted flag with wrong status");
`endif

endmodule

### src/rolt_find_free.sv
// rolt_find_free: priority encoder that picks the lowest free unit of a pool
// depends on rolt_pkg for the result struct and unit width
module rolt_find_free
   import rolt_pkg::*;
(
   input  logic [MAX_UNITS-1:0] free_vec,
   output find_result_type      result
);

   always_comb begin
      result.found = 1'b0;
      result.unit  = '0;
      // scan from the top so the lowest free unit wins
      for (int i = MAX_UNITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            result.found = 1'b1;
            result.unit  = UNIT_BITS'(i);
         end
      end
   end

endmodule

### tb/sv/resource_ownership_lock_table_checker.sv
`timescale 1ns / 1ps
// resource_ownership_lock_table_checker: watches the request and response channels of the
// lock table, predicts every outcome from its own copy of the table and compares fields
// depends on rolt_pkg
module resource_ownership_lock_table_checker
   import rolt_pkg::*;
#(
   parameter int PIN_COUNT     = 64,
   parameter int TIMER_COUNT   = 9,
   parameter int INSTANCE_BITS = 8
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [OP_BITS-1:0]        req_operation,
   input  logic                      req_pool,
   input  logic [UNIT_BITS-1:0]      req_unit_index,
   input  logic [CLASS_BITS-1:0]     req_requester_class,
   input  logic [INST_PORT_BITS-1:0] req_requester_instance,
   input  logic                      rsp_strobe,
   input  logic [STATUS_BITS-1:0]    rsp_status,
   input  logic                      rsp_granted,
   input  logic [UNIT_BITS-1:0]      rsp_chosen_unit,
   input  logic [CLASS_BITS-1:0]     rsp_holder_class,
   input  logic [INST_PORT_BITS-1:0] rsp_holder_instance,
   output int                        mismatch_count,
   output int                        outcomes_outstanding
);

   localparam logic [INST_PORT_BITS-1:0] INST_MASK =
      INST_PORT_BITS'((1 << INSTANCE_BITS) - 1);

   typedef struct packed {
      logic [CLASS_BITS-1:0]     cls;
      logic [INST_PORT_BITS-1:0] inst;
   } owner_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   granted;
      logic [UNIT_BITS-1:0]   unit;
      owner_type              holder;
   } lock_outcome_type;

   // table copy, first index is the pool
   logic             unit_held  [2][MAX_UNITS];
   owner_type        unit_owner [2][MAX_UNITS];
   lock_outcome_type pending_outcomes[$];

   initial mismatch_count = 0;

   task automatic clear_table();
      for (int p = 0; p < 2; p++) begin
         for (int u = 0; u < MAX_UNITS; u++) begin
            unit_held[p][u]  = 1'b0;
            unit_owner[p][u] = '0;
         end
      end
      // timer 0 belongs to the system, instance 0
      unit_held[POOL_TIMERS][0]  = 1'b1;
      unit_owner[POOL_TIMERS][0] = '0;
   endtask

   task automatic predict_lock_outcome(input logic [OP_BITS-1:0] op, input logic pool,
                                       input logic [UNIT_BITS-1:0] unit,
                                       input owner_type requester,
                                       output lock_outcome_type outcome);
      int unit_count;
      bit found;
      unit_count = (pool == POOL_TIMERS) ? TIMER_COUNT : PIN_COUNT;
      if (unit_count > MAX_UNITS) unit_count = MAX_UNITS;
      outcome = '0;
      outcome.unit = unit;
      found = 1'b0;
      if (op == OP_LOCK_ANY) begin
         outcome.status = STATUS_NONE_FREE;
         outcome.unit   = '0;
         for (int i = 0; i < unit_count && !found; i++) begin
            if (!unit_held[pool][i]) begin
               found                = 1'b1;
               unit_held[pool][i]   = 1'b1;
               unit_owner[pool][i]  = requester;
               outcome.status       = STATUS_GRANTED;
               outcome.granted      = 1'b1;
               outcome.unit         = i[UNIT_BITS-1:0];
               outcome.holder       = requester;
            end
         end
      end else if (op == OP_RESERVED || int'(unit) >= unit_count) begin
         outcome.status = STATUS_BAD;
      end else if (op == OP_UNLOCK) begin
         unit_held[pool][unit]  = 1'b0;
         unit_owner[pool][unit] = '0;
         outcome.status         = STATUS_UNLOCKED;
      end else if (!unit_held[pool][unit]) begin
         unit_held[pool][unit]  = 1'b1;
         unit_owner[pool][unit] = requester;
         outcome.status         = STATUS_GRANTED;
         outcome.granted        = 1'b1;
         outcome.holder         = requester;
      end else if (unit_owner[pool][unit] == requester) begin
         outcome.status  = STATUS_GRANTED;
         outcome.granted = 1'b1;
         outcome.holder  = requester;
      end else begin
         outcome.status = STATUS_OTHER;
         outcome.holder = unit_owner[pool][unit];
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] expected,
                                input logic [7:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      lock_outcome_type expected;
      owner_type        requester;
      if (reset) begin
         clear_table();
         pending_outcomes.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: result with nothing pending, status %0d unit %0d",
                        $time, rsp_status, rsp_chosen_unit);
               mismatch_count++;
            end else begin
               expected = pending_outcomes.pop_front();
               compare_field("status", 8'(expected.status), 8'(rsp_status));
               compare_field("granted", 8'(expected.granted), 8'(rsp_granted));
               compare_field("chosen_unit", 8'(expected.unit), 8'(rsp_chosen_unit));
               compare_field("holder_class", 8'(expected.holder.cls), 8'(rsp_holder_class));
               compare_field("holder_instance", expected.holder.inst, rsp_holder_instance);
            end
         end
         if (start && !busy) begin
            requester.cls  = req_requester_class;
            requester.inst = req_requester_instance & INST_MASK;
            predict_lock_outcome(req_operation, req_pool, req_unit_index, requester, expected);
            pending_outcomes.push_back(expected);
         end
      end
      outcomes_outstanding <= pending_outcomes.size();
   end

endmodule

### tb/sv/resource_ownership_lock_table_core_tb.sv
`timescale 1ns / 1ps
// resource_ownership_lock_table_core_tb: drives lock, lock-any and unlock transactions into
// the lock table core and gives the verdict; checking is done by the checker module
// depends on rolt_pkg, resource_ownership_lock_table_core and the checker
module resource_ownership_lock_table_core_tb
   import rolt_pkg::*;
();

   localparam int PIN_COUNT     = 64;
   localparam int TIMER_COUNT   = 9;
   localparam int INSTANCE_BITS = 8;
   localparam int ITEM_TARGET   = 1750;
   localparam int PIN_FILL_STEP = 700;
   localparam int CYCLE_LIMIT   = 200000;

   // owner classes
   localparam logic [CLASS_BITS-1:0] CLASS_SYSTEM  = 3'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_STEPPER = 3'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_PWM     = 3'd2;
   localparam logic [CLASS_BITS-1:0] CLASS_LORA    = 3'd6;
   localparam logic [CLASS_BITS-1:0] CLASS_SEVEN   = 3'd7;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [OP_BITS-1:0]        req_operation;
   logic                      req_pool;
   logic [UNIT_BITS-1:0]      req_unit_index;
   logic [CLASS_BITS-1:0]     req_requester_class;
   logic [INST_PORT_BITS-1:0] req_requester_instance;
   logic                      rsp_strobe;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic                      rsp_granted;
   logic [UNIT_BITS-1:0]      rsp_chosen_unit;
   logic [CLASS_BITS-1:0]     rsp_holder_class;
   logic [INST_PORT_BITS-1:0] rsp_holder_instance;

   int mismatch_count;
   int outcomes_outstanding;
   int cycle_count = 0;
   int sent_count  = 0;
   int burst_left  = 0;

   resource_ownership_lock_table_core #(
      .PIN_COUNT     (PIN_COUNT),
      .TIMER_COUNT   (TIMER_COUNT),
      .INSTANCE_BITS (INSTANCE_BITS)
   ) dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_operation          (req_operation),
      .req_pool               (req_pool),
      .req_unit_index         (req_unit_index),
      .req_requester_class    (req_requester_class),
      .req_requester_instance (req_requester_instance),
      .rsp_strobe             (rsp_strobe),
      .rsp_status             (rsp_status),
      .rsp_granted            (rsp_granted),
      .rsp_chosen_unit        (rsp_chosen_unit),
      .rsp_holder_class       (rsp_holder_class),
      .rsp_holder_instance    (rsp_holder_instance)
   );

   resource_ownership_lock_table_checker #(
      .PIN_COUNT     (PIN_COUNT),
      .TIMER_COUNT   (TIMER_COUNT),
      .INSTANCE_BITS (INSTANCE_BITS)
   ) lock_checker (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_operation          (req_operation),
      .req_pool               (req_pool),
      .req_unit_index         (req_unit_index),
      .req_requester_class    (req_requester_class),
      .req_requester_instance (req_requester_instance),
      .rsp_strobe             (rsp_strobe),
      .rsp_status             (rsp_status),
      .rsp_granted            (rsp_granted),
      .rsp_chosen_unit        (rsp_chosen_unit),
      .rsp_holder_class       (rsp_holder_class),
      .rsp_holder_instance    (rsp_holder_instance),
      .mismatch_count         (mismatch_count),
      .outcomes_outstanding   (outcomes_outstanding)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog: a hung handshake or a lost result ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("resource_ownership_lock_table_core_tb: done, errors");
         $finish;
      end
   end

   // drop start and wait out the idle gap given by n
   task automatic idle_sender(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // wait until the checker has nothing outstanding; the first edge lets the
   // count catch up with a transaction accepted at the current edge
   task automatic drain_outcomes();
      start <= 1'b0;
      do @(posedge clock); while (outcomes_outstanding != 0);
   endtask

   // present one transaction and hold it until the core takes it; start stays
   // high afterwards so back-to-back transactions need no second assignment
   task automatic send_request(input logic [OP_BITS-1:0] op, input logic pool,
                               input logic [UNIT_BITS-1:0] unit,
                               input logic [CLASS_BITS-1:0] cls,
                               input logic [INST_PORT_BITS-1:0] inst);
      req_operation          <= op;
      req_pool               <= pool;
      req_unit_index         <= unit;
      req_requester_class    <= cls;
      req_requester_instance <= inst;
      start                  <= 1'b1;
      do @(posedge clock); while (busy);
      sent_count++;
      // bursts of up to 24 transactions, usually followed by a gap
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
      end
   endtask

   // owners come mostly from a small set so that re-locks by the same owner happen
   task automatic pick_owner(output logic [CLASS_BITS-1:0] cls,
                             output logic [INST_PORT_BITS-1:0] inst);
      cls  = CLASS_BITS'($urandom_range(0, 7));
      inst = ($urandom_range(0, 4) == 0) ? INST_PORT_BITS'($urandom_range(0, 255))
                                         : INST_PORT_BITS'($urandom_range(0, 3));
   endtask

   // unit within the pool most of the time, anywhere in the field otherwise
   function automatic logic [UNIT_BITS-1:0] pick_unit(input logic pool);
      if (pool == POOL_TIMERS && $urandom_range(0, 6) != 0)
         return UNIT_BITS'($urandom_range(0, TIMER_COUNT - 1));
      return UNIT_BITS'($urandom_range(0, 63));
   endfunction

   initial begin
      logic [OP_BITS-1:0]        op;
      logic                      pool;
      logic [UNIT_BITS-1:0]      unit;
      logic [CLASS_BITS-1:0]     cls;
      logic [CLASS_BITS-1:0]     other_cls;
      logic [INST_PORT_BITS-1:0] inst;
      logic [INST_PORT_BITS-1:0] other_inst;
      int                        kind;
      int                        roll;
      int                        next_pin_fill;

      reset                  = 1'b1;
      start                  = 1'b0;
      req_operation          = OP_LOCK;
      req_pool               = POOL_PINS;
      req_unit_index         = '0;
      req_requester_class    = CLASS_SYSTEM;
      req_requester_instance = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: grant, same-owner re-lock, held by other, range edges
      send_request(OP_LOCK, POOL_PINS, 6'd0, CLASS_STEPPER, 8'd0);
      send_request(OP_LOCK, POOL_PINS, 6'd0, CLASS_STEPPER, 8'd0);
      send_request(OP_LOCK, POOL_PINS, 6'd0, CLASS_PWM, 8'd0);
      send_request(OP_LOCK, POOL_PINS, 6'd63, CLASS_SEVEN, 8'd255);
      send_request(OP_LOCK, POOL_PINS, 6'd63, CLASS_SEVEN, 8'd254);
      // timer 0 starts out held by the system
      send_request(OP_LOCK, POOL_TIMERS, 6'd0, CLASS_LORA, 8'd1);
      send_request(OP_LOCK, POOL_TIMERS, 6'd0, CLASS_SYSTEM, 8'd0);
      // unit past the pool end, and the reserved operation
      send_request(OP_LOCK, POOL_TIMERS, 6'd9, CLASS_PWM, 8'd7);
      send_request(OP_UNLOCK, POOL_TIMERS, 6'd63, CLASS_PWM, 8'd7);
      send_request(OP_RESERVED, POOL_PINS, 6'd42, CLASS_LORA, 8'd170);
      // unlock of a free pin, then of a held one
      send_request(OP_UNLOCK, POOL_PINS, 6'd5, CLASS_SEVEN, 8'd85);
      send_request(OP_UNLOCK, POOL_PINS, 6'd0, CLASS_PWM, 8'd3);
      send_request(OP_LOCK_ANY, POOL_PINS, 6'd21, CLASS_PWM, 8'd128);
      // take every timer, then one more to hit the none-free case
      repeat (TIMER_COUNT) send_request(OP_LOCK_ANY, POOL_TIMERS, 6'd63, CLASS_LORA, 8'd9);
      send_request(OP_UNLOCK, POOL_TIMERS, 6'd0, CLASS_STEPPER, 8'd1);
      send_request(OP_LOCK_ANY, POOL_TIMERS, 6'd0, CLASS_SEVEN, 8'd64);
      // let everything come back before going random
      drain_outcomes();

      next_pin_fill = PIN_FILL_STEP;
      while (sent_count < ITEM_TARGET) begin
         if (sent_count >= next_pin_fill) begin
            // exhaust the pin pool through lock-any, then free most of it
            next_pin_fill += PIN_FILL_STEP;
            repeat (PIN_COUNT + 2) begin
               pick_owner(cls, inst);
               send_request(OP_LOCK_ANY, POOL_PINS, UNIT_BITS'($urandom_range(0, 63)),
                            cls, inst);
            end
            drain_outcomes();
            for (int u = 0; u < PIN_COUNT; u++) begin
               if ($urandom_range(0, 3) != 0) begin
                  pick_owner(cls, inst);
                  send_request(OP_UNLOCK, POOL_PINS, UNIT_BITS'(u), cls, inst);
               end
            end
         end
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            // single transaction, mostly well formed
            roll = $urandom_range(0, 99);
            if (roll < 40)      op = OP_LOCK;
            else if (roll < 65) op = OP_LOCK_ANY;
            else if (roll < 95) op = OP_UNLOCK;
            else                op = OP_RESERVED;
            pool = 1'($urandom_range(0, 1));
            pick_owner(cls, inst);
            send_request(op, pool, pick_unit(pool), cls, inst);
         end else if (kind < 85) begin
            // ownership session: lock, re-lock, contend from another owner, release
            pool = 1'($urandom_range(0, 1));
            unit = (pool == POOL_TIMERS) ? UNIT_BITS'($urandom_range(0, TIMER_COUNT - 1))
                                         : UNIT_BITS'($urandom_range(0, PIN_COUNT - 1));
            pick_owner(cls, inst);
            other_cls  = cls;
            other_inst = inst;
            if ($urandom_range(0, 1) != 0) begin
               other_cls = cls ^ CLASS_BITS'($urandom_range(1, 7));
            end else begin
               other_inst = inst ^ INST_PORT_BITS'($urandom_range(1, 255));
            end
            send_request(OP_LOCK, pool, unit, cls, inst);
            send_request(OP_LOCK, pool, unit, cls, inst);
            send_request(OP_LOCK, pool, unit, other_cls, other_inst);
            if ($urandom_range(0, 3) != 0) send_request(OP_UNLOCK, pool, unit, cls, inst);
         end else if (kind < 95) begin
            // run the timer pool dry, then give a few back
            repeat (TIMER_COUNT + 1) begin
               pick_owner(cls, inst);
               send_request(OP_LOCK_ANY, POOL_TIMERS, UNIT_BITS'($urandom_range(0, 63)),
                            cls, inst);
            end
            repeat ($urandom_range(1, 3)) begin
               pick_owner(cls, inst);
               send_request(OP_UNLOCK, POOL_TIMERS,
                            UNIT_BITS'($urandom_range(0, TIMER_COUNT - 1)), cls, inst);
            end
         end else begin
            // noise: any field value at all
            repeat (3) begin
               send_request(OP_BITS'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            UNIT_BITS'($urandom_range(0, 63)),
                            CLASS_BITS'($urandom_range(0, 7)),
                            INST_PORT_BITS'($urandom_range(0, 255)));
            end
         end
      end

      drain_outcomes();
      // a few more cycles to catch a stray result
      repeat (6) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("resource_ownership_lock_table_core_tb: done, clean");
      end else begin
         $display("resource_ownership_lock_table_core_tb: done, errors");
      end
      $finish;
   end

endmodule

### files.f
src/rolt_pkg.sv
src/rolt_find_free.sv
src/resource_ownership_lock_table_core.sv
tb/sv/resource_ownership_lock_table_checker.sv
tb/sv/resource_ownership_lock_table_core_tb.sv
